FILE: hw/rtl/httc_pkg.sv
`default_nettype none

package httc_pkg;

  // Largest number of samples in one tile, and the height sample width.
  localparam int unsigned MAX_TILE_SAMPLES = 1024;
  localparam int unsigned HEIGHT_BITS      = 16;

  // The sample counters must be able to hold MAX_TILE_SAMPLES itself.
  localparam int unsigned CNT_W   = $clog2(MAX_TILE_SAMPLES + 1);
  // Ten times a count needs four more bits.
  localparam int unsigned RATIO_W = CNT_W + 4;
  // A height difference needs one more bit.
  localparam int unsigned SPAN_W  = HEIGHT_BITS + 1;

  // Widths of the fixed register and result fields.
  localparam int unsigned SPAN_LIMIT_W = 15;
  localparam int unsigned QUOTA_W      = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned REC_IDX_W    = 17;

  localparam logic [SPAN_LIMIT_W-1:0] SPAN_LIMIT_RESET = SPAN_LIMIT_W'(20);
  localparam logic [QUOTA_W-1:0]      QUOTA_RESET      = QUOTA_W'(1000);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA      = CFG_IDX_W'(1);

  // Extreme height values used to seed the running minimum and maximum.
  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic signed [HEIGHT_BITS-1:0] HEIGHT_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    CLASS_UNUSABLE      = 2'd0,
    CLASS_TRAVERSABLE   = 2'd1,
    CLASS_UNTRAVERSABLE = 2'd2,
    CLASS_SATURATED     = 2'd3
  } tile_class_e;

  // Statistics of one finished tile.
  typedef struct packed {
    logic [CNT_W-1:0]              samples;
    logic [CNT_W-1:0]              valids;
    logic signed [HEIGHT_BITS-1:0] low;
    logic signed [HEIGHT_BITS-1:0] high;
  } tile_stats_t;

  // Current register values.
  typedef struct packed {
    logic [SPAN_LIMIT_W-1:0] span_limit;
    logic [QUOTA_W-1:0]      quota;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/httc_if.sv
`default_nettype none

// Sample channel: one height sample per beat.
interface httc_in_if import httc_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic                          sample_valid;
  logic signed [HEIGHT_BITS-1:0] height;
  logic                          tile_end;

  modport source (output valid, sample_valid, height, tile_end, input ready);
  modport sink   (input valid, sample_valid, height, tile_end, output ready);
endinterface

// Result channel: one tile class per beat.
interface httc_out_if import httc_pkg::*;;
  logic                 valid;
  logic                 ready;
  tile_class_e          tile_class;
  logic                 recorded;
  logic [REC_IDX_W-1:0] record_index;

  modport source (output valid, tile_class, recorded, record_index, input ready);
  modport sink   (input valid, tile_class, recorded, record_index, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/httc_accum.sv
`default_nettype none

// Per-tile accumulation: counts and height extremes, handed off at tile end.
module httc_accum import httc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  httc_in_if.sink     in_i,
  output tile_stats_t tile_o,
  output logic        tile_valid_o,
  input  wire logic   tile_ready_i
);

  logic [CNT_W-1:0]              samples_q, valids_q;
  logic signed [HEIGHT_BITS-1:0] low_q, high_q;
  logic [CNT_W-1:0]              samples_d, valids_d;
  logic signed [HEIGHT_BITS-1:0] low_d, high_d;
  tile_stats_t                   tile_q;
  logic                          tile_valid_q;
  logic                          in_beat;
  logic                          close_tile;

  // A sample is taken whenever the hand-off register is free or draining.
  assign in_i.ready = !tile_valid_q || tile_ready_i;
  assign in_beat    = in_i.valid && in_i.ready;

  // Running values including the current sample.
  always_comb begin
    samples_d = samples_q + CNT_W'(1);
    valids_d  = in_i.sample_valid ? valids_q + CNT_W'(1) : valids_q;
    low_d     = (in_i.sample_valid && (in_i.height < low_q)) ? in_i.height : low_q;
    high_d    = (in_i.sample_valid && (in_i.height > high_q)) ? in_i.height : high_q;
  end

  // An oversized tile closes as if the end flag were set.
  assign close_tile = in_i.tile_end || (samples_d >= CNT_W'(MAX_TILE_SAMPLES));

  // Accumulators restart after each tile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= '0;
      valids_q  <= '0;
      low_q     <= HEIGHT_MAX;
      high_q    <= HEIGHT_MIN;
    end else if (in_beat) begin
      if (close_tile) begin
        samples_q <= '0;
        valids_q  <= '0;
        low_q     <= HEIGHT_MAX;
        high_q    <= HEIGHT_MIN;
      end else begin
        samples_q <= samples_d;
        valids_q  <= valids_d;
        low_q     <= low_d;
        high_q    <= high_d;
      end
    end
  end

  // Hand-off register with the final statistics of a tile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_valid_q <= 1'b0;
    end else if (in_beat && close_tile) begin
      tile_valid_q <= 1'b1;
    end else if (tile_ready_i) begin
      tile_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && close_tile) begin
      tile_q <= '{samples: samples_d, valids: valids_d, low: low_d, high: high_d};
    end
  end

  assign tile_o       = tile_q;
  assign tile_valid_o = tile_valid_q;

  // The open tile never reaches the size limit.
  a_samples_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_q < CNT_W'(MAX_TILE_SAMPLES))
    else $error("open tile holds too many samples");

  // Once a valid sample is seen, the extremes are ordered.
  a_extremes_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valids_q != '0) |-> (low_q <= high_q))
    else $error("lowest height above highest height");

  // A sample that does not close the tile advances the count by one.
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !close_tile) |=> (samples_q == $past(samples_q) + CNT_W'(1)))
    else $error("sample count did not advance");

endmodule

`default_nettype wire

FILE: hw/rtl/httc_classify.sv
`default_nettype none

// Tile classification, quota tracking and the result register.
module httc_classify import httc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire tile_stats_t tile_i,
  input  wire logic        tile_valid_i,
  output logic             tile_ready_o,
  httc_out_if.source       out_o
);

  logic [QUOTA_W-1:0]   trav_total_q, untrav_total_q;
  logic [REC_IDX_W-1:0] rec_count_q;
  logic                 out_valid_q;
  tile_class_e          out_class_q;
  logic                 out_rec_q;
  logic [REC_IDX_W-1:0] out_idx_q;

  logic [RATIO_W-1:0]   valid_x10, samples_x3;
  logic signed [SPAN_W-1:0] span;
  logic                 too_sparse, span_small;
  tile_class_e          cls;
  logic                 rec;
  logic                 tile_beat;

  assign tile_ready_o = !out_valid_q || out_o.ready;
  assign tile_beat    = tile_valid_i && tile_ready_o;

  // Coverage test by shift-and-add: 10*valid < 3*total.
  always_comb begin
    valid_x10  = (RATIO_W'(tile_i.valids) << 3) + (RATIO_W'(tile_i.valids) << 1);
    samples_x3 = (RATIO_W'(tile_i.samples) << 1) + RATIO_W'(tile_i.samples);
    too_sparse = (tile_i.valids == '0) || (valid_x10 < samples_x3);
    span       = SPAN_W'(tile_i.high) - SPAN_W'(tile_i.low);
    span_small = $unsigned(span) < SPAN_W'(cfg_i.span_limit);
  end

  // Class selection, with saturation once a class has met its quota.
  always_comb begin
    if (too_sparse) begin
      cls = CLASS_UNUSABLE;
    end else if (span_small) begin
      cls = (trav_total_q >= cfg_i.quota) ? CLASS_SATURATED : CLASS_TRAVERSABLE;
    end else begin
      cls = (untrav_total_q >= cfg_i.quota) ? CLASS_SATURATED : CLASS_UNTRAVERSABLE;
    end
    rec = (cls == CLASS_TRAVERSABLE) || (cls == CLASS_UNTRAVERSABLE);
  end

  // Class totals and the running record index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trav_total_q   <= '0;
      untrav_total_q <= '0;
      rec_count_q    <= '0;
    end else if (tile_beat && rec) begin
      rec_count_q <= rec_count_q + REC_IDX_W'(1);
      if (cls == CLASS_TRAVERSABLE) begin
        trav_total_q <= trav_total_q + QUOTA_W'(1);
      end else begin
        untrav_total_q <= untrav_total_q + QUOTA_W'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tile_ready_o) begin
      out_valid_q <= tile_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tile_beat) begin
      out_class_q <= cls;
      out_rec_q   <= rec;
      out_idx_q   <= rec ? rec_count_q : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tile_class   = out_class_q;
  assign out_o.recorded     = out_rec_q;
  assign out_o.record_index = out_idx_q;

  // The recorded flag agrees with the class of the pending beat.
  a_rec_matches_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rec_q == ((out_class_q == CLASS_TRAVERSABLE) ||
                                   (out_class_q == CLASS_UNTRAVERSABLE))))
    else $error("recorded flag disagrees with tile class");

  // A tile that is not recorded carries a zero index.
  a_idle_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rec_q) |-> (out_idx_q == '0))
    else $error("record index set on an unrecorded tile");

  // Each recorded tile advances the record index by exactly one.
  a_rec_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tile_beat && rec) |=> (rec_count_q == $past(rec_count_q) + REC_IDX_W'(1)))
    else $error("record index did not advance");

endmodule

`default_nettype wire

FILE: hw/rtl/height_tile_traversability_classifier.sv
// Result path: a tile's result is offered once its last sample beat has passed
//   through the statistics hand-off register, then the result register.
// Throughput: one sample beat per cycle while the hand-off register can drain;
//   tiles may follow one another back to back, down to one sample each.
// Reset (rst_ni, asynchronous, active low) clears the open tile, the class
//   totals and the record index, and loads the register defaults 20 and 1000.
`default_nettype none

module height_tile_traversability_classifier import httc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  httc_in_if.sink                    in_i,
  httc_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t        cfg_q, cfg_d;
  tile_stats_t tile;
  logic        tile_valid, tile_ready;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPAN_LIMIT: cfg_d.span_limit = cfg_data_i[SPAN_LIMIT_W-1:0];
        REG_QUOTA:      cfg_d.quota      = cfg_data_i[QUOTA_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{span_limit: SPAN_LIMIT_RESET, quota: QUOTA_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  httc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .tile_o       (tile),
    .tile_valid_o (tile_valid),
    .tile_ready_i (tile_ready)
  );

  httc_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tile_i       (tile),
    .tile_valid_i (tile_valid),
    .tile_ready_o (tile_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb_height_tile_traversability_classifier.sv
`default_nettype none

module tb_height_tile_traversability_classifier;
  import httc_pkg::*;

  localparam int ITEMS_TARGET   = 1550;
  localparam int NUM_PHASES     = 7;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic                          sample_valid;
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          tile_end;
  } height_sample_t;

  typedef struct {
    tile_class_e          tile_class;
    logic                 recorded;
    logic [REC_IDX_W-1:0] record_index;
  } tile_verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  httc_in_if  sample_ch ();
  httc_out_if class_ch ();

  height_tile_traversability_classifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (sample_ch.sink),
    .out_o      (class_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Samples waiting to be sent and tile verdicts waiting to come out.
  height_sample_t samples_to_send[$];
  tile_verdict_t  pending_verdicts[$];

  // Shadow of the classifier: open tile, class totals and registers.
  int                            tile_samples   = 0;
  int                            tile_valids    = 0;
  logic signed [HEIGHT_BITS-1:0] tile_low       = HEIGHT_MAX;
  logic signed [HEIGHT_BITS-1:0] tile_high      = HEIGHT_MIN;
  int                            trav_total     = 0;
  int                            untrav_total   = 0;
  logic [REC_IDX_W-1:0]          next_record    = '0;
  logic [SPAN_LIMIT_W-1:0]       span_limit_now = SPAN_LIMIT_RESET;
  logic [QUOTA_W-1:0]            quota_now      = QUOTA_RESET;

  // Bookkeeping shared by the processes.
  int             items_queued  = 0;
  int             mismatches    = 0;
  int             tiles_checked = 0;
  int             idle_odds     = 6;
  int             quiet_cycles  = 0;
  bit             beat_held     = 1'b0;
  int             gap_left      = 0;
  int             stall_left    = 0;
  int             hold_left     = 0;
  bit             held_once     = 1'b0;
  height_sample_t current_beat;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Update the shadow with one accepted sample; a closing sample yields a verdict.
  task automatic classify_sample(input height_sample_t s);
    tile_verdict_t v;
    int            span;
    bit            closes;
    tile_samples++;
    if (s.sample_valid) begin
      tile_valids++;
      if (s.height < tile_low) tile_low = s.height;
      if (s.height > tile_high) tile_high = s.height;
    end
    closes = s.tile_end || (tile_samples >= MAX_TILE_SAMPLES);
    if (closes) begin
      span = int'(tile_high) - int'(tile_low);
      if (tile_valids == 0 || tile_valids * 10 < tile_samples * 3) begin
        v.tile_class = CLASS_UNUSABLE;
      end else if (span < int'(span_limit_now)) begin
        v.tile_class = CLASS_TRAVERSABLE;
      end else begin
        v.tile_class = CLASS_UNTRAVERSABLE;
      end
      if (v.tile_class == CLASS_TRAVERSABLE && trav_total >= int'(quota_now)) begin
        v.tile_class = CLASS_SATURATED;
      end
      if (v.tile_class == CLASS_UNTRAVERSABLE && untrav_total >= int'(quota_now)) begin
        v.tile_class = CLASS_SATURATED;
      end
      v.recorded     = 1'b0;
      v.record_index = '0;
      if (v.tile_class == CLASS_TRAVERSABLE || v.tile_class == CLASS_UNTRAVERSABLE) begin
        v.recorded     = 1'b1;
        v.record_index = next_record;
        next_record    = next_record + 1'b1;
        if (v.tile_class == CLASS_TRAVERSABLE) trav_total++;
        else untrav_total++;
      end
      pending_verdicts.push_back(v);
      tile_samples = 0;
      tile_valids  = 0;
      tile_low     = HEIGHT_MAX;
      tile_high    = HEIGHT_MIN;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at tile %0d: %s", tiles_checked, what);
    mismatches++;
  endtask

  // Sample driver: holds each beat until it is taken, with random gaps between beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
      beat_held = 1'b0;
      gap_left  = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        classify_sample(current_beat);
        beat_held = 1'b0;
      end
      if (!beat_held) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_ch.valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          gap_left = $urandom_range(0, 18);
          sample_ch.valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          current_beat = samples_to_send.pop_front();
          beat_held    = 1'b1;
          sample_ch.valid        <= 1'b1;
          sample_ch.sample_valid <= current_beat.sample_valid;
          sample_ch.height       <= current_beat.height;
          sample_ch.tile_end     <= current_beat.tile_end;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Verdict monitor: checks each beat and drives ready, with stall bursts
  // and one long hold-off that backs the block up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    tile_verdict_t want;
    if (!rst_ni) begin
      class_ch.ready <= 1'b0;
    end else begin
      if (class_ch.valid && class_ch.ready) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected verdict class %0d", class_ch.tile_class));
        end else begin
          want = pending_verdicts.pop_front();
          if (class_ch.tile_class !== want.tile_class)
            flag_mismatch($sformatf("tile_class %0d, expected %0d",
                                    class_ch.tile_class, want.tile_class));
          if (class_ch.recorded !== want.recorded)
            flag_mismatch($sformatf("recorded %0b, expected %0b",
                                    class_ch.recorded, want.recorded));
          if (class_ch.record_index !== want.record_index)
            flag_mismatch($sformatf("record_index %0d, expected %0d",
                                    class_ch.record_index, want.record_index));
        end
        tiles_checked++;
      end
      if (!held_once && tiles_checked >= HOLD_AFTER && idle_odds != 0) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        class_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        class_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(0, 18);
        class_ch.ready <= 1'b0;
      end else begin
        class_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_ch.valid && sample_ch.ready) || (class_ch.valid && class_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** height_tile_traversability_classifier: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_sample(input logic v, input logic signed [HEIGHT_BITS-1:0] h,
                             input logic last);
    height_sample_t s;
    s.sample_valid = v;
    s.height       = h;
    s.tile_end     = last;
    samples_to_send.push_back(s);
    items_queued++;
  endtask

  // One tile of random content; heights stay within a chosen spread so that
  // spans land below, at and above the current limit.
  task automatic queue_random_tile(input int n, input bit closed);
    int spread;
    int base;
    int valid_pct;
    int offset;
    bit near_limit;
    near_limit = 1'b0;
    case ($urandom_range(0, 3))
      0: spread = $urandom_range(0, 3);
      1: spread = $urandom_range(0, 2 * int'(span_limit_now));
      2: spread = 65535;
      default: begin
        spread     = int'(span_limit_now);
        near_limit = 1'b1;
      end
    endcase
    base = -32768 + int'($urandom_range(0, 65535 - spread));
    case ($urandom_range(0, 4))
      0: valid_pct = 100;
      1: valid_pct = 70;
      2: valid_pct = 30;
      3: valid_pct = 10;
      default: valid_pct = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      if (near_limit) begin
        case ($urandom_range(0, 2))
          0: offset = 0;
          1: offset = (spread > 0) ? spread - 1 : 0;
          default: offset = spread;
        endcase
      end else begin
        offset = $urandom_range(0, spread);
      end
      push_sample($urandom_range(1, 100) <= valid_pct, HEIGHT_BITS'(base + offset),
                  closed && (k == n - 1));
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SPAN_LIMIT: span_limit_now = value[SPAN_LIMIT_W-1:0];
      REG_QUOTA:      quota_now      = value[QUOTA_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every sample is taken and every verdict is back, then let
  // the pipeline settle.
  task automatic wait_for_drain();
    while (samples_to_send.size() != 0 || beat_held) @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus sequencer.
  initial begin
    int span_plan[NUM_PHASES];
    int quota_plan[NUM_PHASES];
    int odds_plan[NUM_PHASES];
    int phase_end;
    int n;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = REG_SPAN_LIMIT;
    cfg_data_i             = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_valid = 1'b0;
    sample_ch.height       = '0;
    sample_ch.tile_end     = 1'b0;
    class_ch.ready         = 1'b0;
    span_plan  = '{0, 32767, 20, 64, 1, $urandom_range(0, 32767), $urandom_range(0, 32767)};
    quota_plan = '{1000, 65535, 1000, 0, 65535, 3, $urandom_range(0, 65535)};
    odds_plan  = '{8, 0, 16, 4, 8, 24, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed tiles under the reset register values.
    push_sample(1'b1, 16'sd0, 1'b1);          // lone valid sample, zero span
    push_sample(1'b0, HEIGHT_MAX, 1'b1);      // no valid sample at all
    push_sample(1'b1, HEIGHT_MIN, 1'b0);      // widest possible span
    push_sample(1'b1, HEIGHT_MAX, 1'b1);
    push_sample(1'b1, 16'sd5, 1'b0);          // span just under the limit,
    push_sample(1'b0, HEIGHT_MIN, 1'b0);      // missing height must be ignored
    push_sample(1'b1, 16'sd24, 1'b1);
    push_sample(1'b1, 16'sd100, 1'b0);        // span equal to the limit
    push_sample(1'b1, 16'sd120, 1'b1);
    push_sample(1'b0, -16'sd1, 1'b0);         // one valid in three is still usable
    push_sample(1'b1, -16'sd7, 1'b0);
    push_sample(1'b0, 16'sd3, 1'b1);
    push_sample(1'b0, 16'sd9, 1'b0);          // one valid in four is unusable
    push_sample(1'b0, 16'sd9, 1'b0);
    push_sample(1'b1, 16'sd9, 1'b0);
    push_sample(1'b0, 16'sd9, 1'b1);
    push_sample(1'b1, -16'sd300, 1'b0);       // left open across the next write
    wait_for_drain();
    items_queued = 0;

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(REG_SPAN_LIMIT, {1'($urandom_range(0, 1)), 15'(span_plan[p])});
      write_register(REG_QUOTA, CFG_DATA_W'(quota_plan[p]));
      idle_odds = odds_plan[p];
      phase_end = (ITEMS_TARGET * (p + 1)) / NUM_PHASES;
      if (p == 2) queue_random_tile(MAX_TILE_SAMPLES, 1'($urandom_range(0, 1)));
      while (items_queued < phase_end) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        queue_random_tile(n, 1'b1);
      end
      if (p != NUM_PHASES - 1 && $urandom_range(0, 2) == 0) begin
        queue_random_tile($urandom_range(1, 6), 1'b0);
      end
      wait_for_drain();
    end

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("** height_tile_traversability_classifier: PASSED **");
    end else begin
      $display("** height_tile_traversability_classifier: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/httc_pkg.sv
hw/rtl/httc_if.sv
hw/rtl/httc_accum.sv
hw/rtl/httc_classify.sv
hw/rtl/height_tile_traversability_classifier.sv
sim/tb_height_tile_traversability_classifier.sv
